[src/chbd_pkg.sv]
`timescale 1ns / 1ps

package chbd_pkg;

	localparam int MAX_LENGTH_DEF = 32;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 6;
	localparam int WORD_W = 32;
	localparam int LEN_W  = 6;

	// value of max_code_length after reset
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd32;

	typedef enum logic [OP_W-1:0] {
		OP_WR_FIRST = 2'd0,
		OP_WR_BASE  = 2'd1,
		OP_DECODE   = 2'd2,
		OP_SET_POS  = 2'd3
	} op_t;

endpackage

[src/canonical_huffman_bit_decoder.sv]
`timescale 1ns / 1ps

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-------------------------------------------
// item     | in        | item_valid / item_stall   | op, table_index, table_value, code_bit
// result   | out       | result_valid / result_stall | symbol_rank, code_length, next_position,
//          |           |                           | length_error
// cfg      | in        | cfg_valid / cfg_ready     | cfg_data (max_code_length)
//
// One item per cycle sustained while no stalled result holds the input register. An accepted
// item sits in the input register while the decode step (one add/compare against the prefetched
// table entries) runs, and its result, if any, then moves into the result register (result_valid).
// The table entries for the next code length are read ahead from the two tables into registers.
// Reset clears the tables through per-entry valid bits; no sweep is needed.
// A stalled result only holds the input register when that item would emit a result.

module canonical_huffman_bit_decoder #(
	parameter int MAX_LENGTH = chbd_pkg::MAX_LENGTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [chbd_pkg::OP_W-1:0]       op,
	input  logic [chbd_pkg::IDX_W-1:0]      table_index,
	input  logic [chbd_pkg::WORD_W-1:0]     table_value,
	input  logic                            code_bit,

	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [chbd_pkg::WORD_W-1:0]     symbol_rank,
	output logic [chbd_pkg::LEN_W-1:0]      code_length,
	output logic [chbd_pkg::WORD_W-1:0]     next_position,
	output logic                            length_error,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [chbd_pkg::LEN_W-1:0]      cfg_data
);

	localparam int DEPTH = MAX_LENGTH + 1;
	localparam int AW    = $clog2(DEPTH);

	// input register
	logic                            valid_s1;
	chbd_pkg::op_t                   op_s1;
	logic [chbd_pkg::IDX_W-1:0]      index_s1;
	logic [chbd_pkg::WORD_W-1:0]     value_s1;
	logic                            bit_s1;

	// decoder state
	logic [chbd_pkg::WORD_W-1:0]     partial_q;
	logic [chbd_pkg::LEN_W-1:0]      cur_len_q;
	logic [chbd_pkg::WORD_W-1:0]     pos_q;
	logic [chbd_pkg::LEN_W-1:0]      max_len_q;

	// tables and prefetched entries for length cur_len_q + 1
	logic [chbd_pkg::WORD_W-1:0]     first_mem [DEPTH];
	logic [chbd_pkg::WORD_W-1:0]     base_mem  [DEPTH];
	logic [DEPTH-1:0]                first_vld_q;
	logic [DEPTH-1:0]                base_vld_q;
	logic [chbd_pkg::WORD_W-1:0]     first_rd_q;
	logic [chbd_pkg::WORD_W-1:0]     base_rd_q;

	// result register
	logic                            res_valid_q;
	logic [chbd_pkg::WORD_W-1:0]     rank_q;
	logic [chbd_pkg::LEN_W-1:0]      len_q;
	logic [chbd_pkg::WORD_W-1:0]     npos_q;
	logic                            err_q;

	logic                            in_fire;
	logic                            fire;
	logic                            adv;
	logic                            is_decode;
	logic                            emit;
	logic                            len_err;
	logic                            hit;
	logic [chbd_pkg::LEN_W-1:0]      lim;
	logic [chbd_pkg::LEN_W-1:0]      len;
	logic [chbd_pkg::WORD_W-1:0]     pc_new;
	logic [chbd_pkg::WORD_W-1:0]     pos_inc;
	logic [chbd_pkg::WORD_W-1:0]     rank;

	logic [chbd_pkg::WORD_W-1:0]     partial_d;
	logic [chbd_pkg::LEN_W-1:0]      cur_len_d;
	logic [chbd_pkg::WORD_W-1:0]     pos_d;
	logic [chbd_pkg::LEN_W-1:0]      raddr_full;
	logic [AW-1:0]                   raddr;
	logic                            rd_ok;
	logic [AW-1:0]                   waddr;
	logic                            idx_ok;
	logic                            we_first;
	logic                            we_base;

	// decode step
	assign lim       = (max_len_q > chbd_pkg::LEN_W'(MAX_LENGTH)) ?
	                   chbd_pkg::LEN_W'(MAX_LENGTH) : max_len_q;
	assign len       = cur_len_q + 6'd1;
	assign pc_new    = {partial_q[chbd_pkg::WORD_W-2:0], bit_s1};
	assign pos_inc   = pos_q + 32'd1;
	assign len_err   = len > lim;
	assign hit       = pc_new >= first_rd_q;
	assign rank      = base_rd_q + pc_new - first_rd_q;
	assign is_decode = valid_s1 && (op_s1 == chbd_pkg::OP_DECODE);
	assign emit      = is_decode && (len_err || hit);

	// only an item that emits has to wait for the result register
	assign adv        = !(emit && res_valid_q && result_stall);
	assign fire       = valid_s1 && adv;
	assign item_stall = valid_s1 && !adv;
	assign in_fire    = item_valid && !item_stall;

	always_comb begin
		partial_d = partial_q;
		cur_len_d = cur_len_q;
		pos_d     = pos_q;
		if (fire) begin
			unique case (op_s1)
				chbd_pkg::OP_SET_POS: begin
					pos_d     = value_s1;
					partial_d = '0;
					cur_len_d = '0;
				end
				chbd_pkg::OP_DECODE: begin
					pos_d = pos_inc;
					if (len_err || hit) begin
						partial_d = '0;
						cur_len_d = '0;
					end else begin
						partial_d = pc_new;
						cur_len_d = len;
					end
				end
				chbd_pkg::OP_WR_FIRST,
				chbd_pkg::OP_WR_BASE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// prefetch address follows the length the next bit will reach;
	// past the deepest length the next bit is an error and the entry is unused
	assign raddr_full = cur_len_d + 6'd1;
	assign raddr      = raddr_full[AW-1:0];
	assign rd_ok      = raddr_full <= chbd_pkg::LEN_W'(MAX_LENGTH);
	assign waddr      = index_s1[AW-1:0];
	assign idx_ok     = index_s1 <= chbd_pkg::IDX_W'(MAX_LENGTH);
	assign we_first   = fire && (op_s1 == chbd_pkg::OP_WR_FIRST) && idx_ok;
	assign we_base    = fire && (op_s1 == chbd_pkg::OP_WR_BASE) && idx_ok;

	always_ff @(posedge clk) begin
		if (we_first) begin
			first_mem[waddr] <= value_s1;
		end
		if (we_base) begin
			base_mem[waddr] <= value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_vld_q <= '0;
			base_vld_q  <= '0;
			first_rd_q  <= '0;
			base_rd_q   <= '0;
		end else begin
			if (we_first) begin
				first_vld_q[waddr] <= 1'b1;
			end
			if (we_base) begin
				base_vld_q[waddr] <= 1'b1;
			end
			// write-through so a table write is seen by the very next bit
			if (we_first && (waddr == raddr)) begin
				first_rd_q <= value_s1;
			end else if (rd_ok && first_vld_q[raddr]) begin
				first_rd_q <= first_mem[raddr];
			end else begin
				first_rd_q <= '0;
			end
			if (we_base && (waddr == raddr)) begin
				base_rd_q <= value_s1;
			end else if (rd_ok && base_vld_q[raddr]) begin
				base_rd_q <= base_mem[raddr];
			end else begin
				base_rd_q <= '0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= chbd_pkg::op_t'(op);
			index_s1 <= table_index;
			value_s1 <= table_value;
			bit_s1   <= code_bit;
		end
	end

	// state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			cur_len_q <= '0;
			pos_q     <= '0;
			max_len_q <= chbd_pkg::MAX_LEN_RESET;
		end else begin
			partial_q <= partial_d;
			cur_len_q <= cur_len_d;
			pos_q     <= pos_d;
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
		end
	end

	assign cfg_ready = 1'b1;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			rank_q <= len_err ? '0 : rank;
			len_q  <= len;
			npos_q <= pos_inc;
			err_q  <= len_err;
		end
	end

	assign result_valid  = res_valid_q;
	assign symbol_rank   = rank_q;
	assign code_length   = len_q;
	assign next_position = npos_q;
	assign length_error  = err_q;

	// the partial length never reaches the table depth
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_len_q <= chbd_pkg::LEN_W'(MAX_LENGTH))
		else $error("partial code length out of range");

	// an error beat carries a zero rank
	a_err_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && length_error) |-> (symbol_rank == '0))
		else $error("length error with nonzero rank");

	// a decoded code is at least one bit and within the limit in force
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit && !len_err) |=> (code_length != '0 && code_length <= $past(lim)))
		else $error("decoded code length out of range");

	// a position load restarts at a code boundary
	a_set_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == chbd_pkg::OP_SET_POS) |=>
		(cur_len_q == '0 && partial_q == '0 && pos_q == $past(value_s1)))
		else $error("position load did not restart decoding");

	// the input side stalls only with an item held that wants the result register
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (emit && res_valid_q))
		else $error("stall without a blocked result");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_LEN     = chbd_pkg::MAX_LENGTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 6;

	typedef struct {
		logic [chbd_pkg::WORD_W-1:0] rank;
		logic [chbd_pkg::LEN_W-1:0]  len;
		logic [chbd_pkg::WORD_W-1:0] pos;
		logic                        err;
	} symbol_beat_t;

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        item_valid   = 1'b0;
	logic                        item_stall;
	logic [chbd_pkg::OP_W-1:0]   op           = '0;
	logic [chbd_pkg::IDX_W-1:0]  table_index  = '0;
	logic [chbd_pkg::WORD_W-1:0] table_value  = '0;
	logic                        code_bit     = 1'b0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic [chbd_pkg::WORD_W-1:0] symbol_rank;
	logic [chbd_pkg::LEN_W-1:0]  code_length;
	logic [chbd_pkg::WORD_W-1:0] next_position;
	logic                        length_error;
	logic                        cfg_valid    = 1'b0;
	logic                        cfg_ready;
	logic [chbd_pkg::LEN_W-1:0]  cfg_data     = '0;

	// decoder state as predicted by the testbench
	logic [chbd_pkg::WORD_W-1:0] first_code_q [0:MAX_LEN];
	logic [chbd_pkg::WORD_W-1:0] rank_base_q [0:MAX_LEN];
	logic [chbd_pkg::WORD_W-1:0] code_acc;
	logic [chbd_pkg::LEN_W-1:0]  code_len_acc;
	logic [chbd_pkg::WORD_W-1:0] bit_pos;
	logic [chbd_pkg::LEN_W-1:0]  max_len_reg;

	symbol_beat_t pending_symbols [$];
	int mismatch_count = 0;
	int items_sent     = 0;
	int quiet_cycles   = 0;
	int stall_left     = 0;
	int idle_pct       = 0;

	canonical_huffman_bit_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.table_index  (table_index),
		.table_value  (table_value),
		.code_bit     (code_bit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.symbol_rank  (symbol_rank),
		.code_length  (code_length),
		.next_position(next_position),
		.length_error (length_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("%0t ns: mismatch: %s", $realtime, what);
		end
	endtask

	// one accepted item through the decoder; queues the symbol it completes, if any
	task automatic huff_decode_step(input chbd_pkg::op_t kind,
			input logic [chbd_pkg::IDX_W-1:0] idx,
			input logic [chbd_pkg::WORD_W-1:0] val, input logic bit_in);
		symbol_beat_t sym;
		int len;
		int lim;
		case (kind)
			chbd_pkg::OP_WR_FIRST: begin
				if (idx <= MAX_LEN) first_code_q[idx] = val;
			end
			chbd_pkg::OP_WR_BASE: begin
				if (idx <= MAX_LEN) rank_base_q[idx] = val;
			end
			chbd_pkg::OP_SET_POS: begin
				bit_pos      = val;
				code_acc     = '0;
				code_len_acc = '0;
			end
			chbd_pkg::OP_DECODE: begin
				code_acc = {code_acc[chbd_pkg::WORD_W-2:0], bit_in};
				bit_pos  = bit_pos + 32'd1;
				len      = code_len_acc + 1;
				lim      = (max_len_reg > MAX_LEN) ? MAX_LEN : max_len_reg;
				sym.len  = chbd_pkg::LEN_W'(len);
				sym.pos  = bit_pos;
				if (len > lim) begin
					sym.rank = '0;
					sym.err  = 1'b1;
					pending_symbols.push_back(sym);
					code_acc     = '0;
					code_len_acc = '0;
				end else if (code_acc >= first_code_q[len]) begin
					sym.rank = rank_base_q[len] + code_acc - first_code_q[len];
					sym.err  = 1'b0;
					pending_symbols.push_back(sym);
					code_acc     = '0;
					code_len_acc = '0;
				end else begin
					code_len_acc = chbd_pkg::LEN_W'(len);
				end
			end
			default: begin
			end
		endcase
	endtask

	// valid stays up after a beat so back-to-back items need no second assignment
	task automatic send_item(input chbd_pkg::op_t kind, input logic [chbd_pkg::IDX_W-1:0] idx,
			input logic [chbd_pkg::WORD_W-1:0] val, input logic bit_in);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_valid  <= 1'b1;
		op          <= kind;
		table_index <= idx;
		table_value <= val;
		code_bit    <= bit_in;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		huff_decode_step(kind, idx, val, bit_in);
		items_sent++;
	endtask

	task automatic send_random_item();
		chbd_pkg::op_t kind;
		kind = chbd_pkg::op_t'($urandom_range(0, 3));
		send_item(kind, chbd_pkg::IDX_W'($urandom_range(0, 63)), $urandom,
			1'($urandom_range(0, 1)));
	endtask

	// sender holds off until every queued symbol is out, then lets the pipe settle
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_symbols.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [chbd_pkg::LEN_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		max_len_reg = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_table_writes_and_decode();
		// empty tables: every bit is a complete one-bit code
		send_item(chbd_pkg::OP_DECODE, '0, $urandom, 1'b0);
		send_item(chbd_pkg::OP_DECODE, '1, $urandom, 1'b1);
		send_item(chbd_pkg::OP_WR_FIRST, 6'd1, 32'hFFFF_FFFF, 1'b0);
		send_item(chbd_pkg::OP_WR_FIRST, 6'd2, 32'd3, 1'b1);
		send_item(chbd_pkg::OP_WR_BASE, 6'd2, 32'hFFFF_FFFF, 1'b0);
		// past the table, dropped
		send_item(chbd_pkg::OP_WR_FIRST, 6'd63, '0, 1'b0);
		send_item(chbd_pkg::OP_WR_BASE, 6'd33, '0, 1'b1);
		// length zero entry is never looked at
		send_item(chbd_pkg::OP_WR_BASE, 6'd0, $urandom, 1'b0);
		send_item(chbd_pkg::OP_WR_FIRST, 6'd0, $urandom, 1'b0);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		// base + code - first wraps
		send_item(chbd_pkg::OP_DECODE, '1, '1, 1'b1);
	endtask

	task automatic test_stream_position();
		send_item(chbd_pkg::OP_SET_POS, '0, 32'hFFFF_FFFF, 1'b0);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		// restart in the middle of a code
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		send_item(chbd_pkg::OP_SET_POS, '1, 32'h0, 1'b1);
		send_item(chbd_pkg::OP_WR_FIRST, 6'd3, '0, 1'b0);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b0);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b0);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
	endtask

	task automatic test_length_limits();
		set_max_len(6'd0);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b0);
		set_max_len(6'd1);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b0);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		// above the table depth, clipped to the full length
		set_max_len(6'd63);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		send_item(chbd_pkg::OP_DECODE, '0, '0, 1'b1);
		set_max_len(6'd32);
	endtask

	// well-formed canonical tables, then whole codes with a few broken beats mixed in
	task automatic test_canonical_streams(input int item_goal, input bit bursty);
		int cnt [0:MAX_LEN];
		logic [chbd_pkg::WORD_W-1:0] lead [0:MAX_LEN];
		logic [chbd_pkg::WORD_W-1:0] base;
		int depth;
		int l;
		int v;
		int pick;
		while (items_sent < item_goal) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
			if (!bursty) idle_pct = 0;
			depth = ($urandom_range(0, 5) == 0) ? $urandom_range(9, MAX_LEN)
			                                    : $urandom_range(1, 8);
			for (l = 1; l <= depth; l++) cnt[l] = $urandom_range(0, 2);
			if (cnt[depth] == 0) cnt[depth] = 1;
			lead[depth] = '0;
			for (l = depth - 1; l >= 1; l--) lead[l] = (lead[l+1] + cnt[l+1] + 1) >> 1;
			set_max_len(chbd_pkg::LEN_W'(($urandom_range(0, 3) == 0) ?
				$urandom_range(depth, 63) : depth));
			base = ($urandom_range(0, 3) == 0) ? $urandom : '0;
			for (l = 1; l <= depth; l++) begin
				send_item(chbd_pkg::OP_WR_FIRST, chbd_pkg::IDX_W'(l), lead[l],
					1'($urandom_range(0, 1)));
				send_item(chbd_pkg::OP_WR_BASE, chbd_pkg::IDX_W'(l), base,
					1'($urandom_range(0, 1)));
				base = base + cnt[l];
			end
			send_item(chbd_pkg::OP_SET_POS, chbd_pkg::IDX_W'($urandom_range(0, 63)),
				($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom,
				1'($urandom_range(0, 1)));
			repeat ($urandom_range(8, 24)) begin
				if (items_sent >= item_goal) break;
				if ($urandom_range(0, 9) == 0) begin
					send_random_item();
				end else begin
					do pick = $urandom_range(1, depth); while (cnt[pick] == 0);
					v = lead[pick] + $urandom_range(0, cnt[pick] - 1);
					for (l = pick - 1; l >= 0; l--) begin
						send_item(chbd_pkg::OP_DECODE, chbd_pkg::IDX_W'($urandom_range(0, 63)),
							$urandom, v[l]);
					end
				end
			end
		end
	endtask

	// random tables and random limits: mostly raw bits, the rest any operation
	task automatic test_random_noise(input int item_goal);
		int l;
		idle_pct = 20;
		set_max_len(chbd_pkg::LEN_W'($urandom_range(0, 63)));
		for (l = 1; l <= MAX_LEN; l++) begin
			send_item(chbd_pkg::OP_WR_FIRST, chbd_pkg::IDX_W'(l),
				$urandom >> $urandom_range(0, 31), 1'($urandom_range(0, 1)));
			send_item(chbd_pkg::OP_WR_BASE, chbd_pkg::IDX_W'(l), $urandom,
				1'($urandom_range(0, 1)));
		end
		while (items_sent < item_goal) begin
			if ($urandom_range(0, 39) == 0) set_max_len(chbd_pkg::LEN_W'($urandom_range(0, 63)));
			if ($urandom_range(0, 9) < 6) begin
				send_item(chbd_pkg::OP_DECODE, chbd_pkg::IDX_W'($urandom_range(0, 63)),
					$urandom, 1'($urandom_range(0, 1)));
			end else begin
				send_random_item();
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 11);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		symbol_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_symbols.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: rank %h len %0d pos %h err %b",
					symbol_rank, code_length, next_position, length_error));
			end else begin
				want = pending_symbols.pop_front();
				if (symbol_rank !== want.rank)
					report_mismatch($sformatf("symbol_rank %h, expected %h",
						symbol_rank, want.rank));
				if (code_length !== want.len)
					report_mismatch($sformatf("code_length %0d, expected %0d",
						code_length, want.len));
				if (next_position !== want.pos)
					report_mismatch($sformatf("next_position %h, expected %h",
						next_position, want.pos));
				if (length_error !== want.err)
					report_mismatch($sformatf("length_error %b, expected %b",
						length_error, want.err));
			end
		end
	end

	// counts cycles with no beat on any channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d symbols outstanding",
				quiet_cycles, pending_symbols.size());
			$display("** canonical_huffman_bit_decoder: FAILED **");
			$finish;
		end
	end

	initial begin : main_seq
		int i;
		for (i = 0; i <= MAX_LEN; i++) begin
			first_code_q[i] = '0;
			rank_base_q[i]  = '0;
		end
		code_acc     = '0;
		code_len_acc = '0;
		bit_pos      = '0;
		max_len_reg  = chbd_pkg::MAX_LEN_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 20;
		test_table_writes_and_decode();
		test_stream_position();
		test_length_limits();
		test_canonical_streams(420, 1'b1);
		test_random_noise(560);
		// last stretch runs back to back on both sides
		idle_pct = 0;
		test_canonical_streams(650, 1'b0);
		drain_results();
		if (mismatch_count == 0) begin
			$display("** canonical_huffman_bit_decoder: PASSED **");
		end else begin
			$display("** canonical_huffman_bit_decoder: FAILED **");
		end
		$finish;
	end

endmodule
